// ----- sv/cgd_pkg.sv -----
// ----------------------------------------------------------------------------
// cgd_pkg
// Shared parameters, codes and helpers of the gridding/degridding engine.
// ----------------------------------------------------------------------------
package cgd_pkg;

  localparam int GRID_SIDE_DEF   = 256;
  localparam int MAX_SUPPORT_DEF = 8;

  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 72;

  localparam logic [2:0] FUNC_WR_KERN = 3'd0;
  localparam logic [2:0] FUNC_WR_CELL = 3'd1;
  localparam logic [2:0] FUNC_RD_CELL = 3'd2;
  localparam logic [2:0] FUNC_GRID    = 3'd3;
  localparam logic [2:0] FUNC_DEGRID  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_SAT     = 2'd2;
  localparam logic [1:0] ST_KIDX    = 2'd3;

  localparam logic [3:0] SUPPORT_RST = 4'd3;

  // {saturated, clamped value}
  function automatic logic [32:0] clamp32(input logic signed [63:0] x);
    logic [32:0] r;
    if (x > 64'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (x < -64'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

endpackage

// ----- sv/convolutional_gridding_degridding.sv -----
// ----------------------------------------------------------------------------
// convolutional_gridding_degridding
// Complex grid and kernel stores with windowed gridding and degridding.
// ----------------------------------------------------------------------------
// channel  | direction | word
// s_axis   | in        | one command word
// m_axis   | out       | one result word per command
// cfg      | in        | support radius
//
// Grid and degrid walk the (2s+1)^2 window, s = min(radius, MAX_SUPPORT),
// one window cell per cycle; grid writes each cell back through the grid
// memory read-modify-write loop. One command is in flight at a time.
// Reset clears control state only; memories hold garbage until written.
// A stalled result holds the block before its next command.
// ----------------------------------------------------------------------------
module convolutional_gridding_degridding #(
  parameter int GRID_SIDE   = cgd_pkg::GRID_SIDE_DEF,
  parameter int MAX_SUPPORT = cgd_pkg::MAX_SUPPORT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // func[2:0] u_index[10:3] v_index[18:11] kern_u[23:19] kern_v[28:24]
  // sample_re[44:29] sample_im[60:45] cell_re[92:61] cell_im[124:93]
  input  logic [cgd_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_re[31:0] out_im[63:32] status[65:64]
  output logic [cgd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [3:0]                     cfg_data_i
);
  import cgd_pkg::*;

  localparam int KSIDE = 2 * MAX_SUPPORT + 1;
  localparam int AW    = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int KW    = $clog2(KSIDE * KSIDE);
  localparam int CW    = ($clog2(GRID_SIDE) > 9 ? $clog2(GRID_SIDE) : 9) + 1;
  localparam int KCW   = ($clog2(KSIDE) > 5 ? $clog2(KSIDE) : 5) + 1;

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN, S_RD, S_DONE} state_e;

  state_e state_q;
  logic [3:0] support_q;
  logic [2:0] mode_q;

  logic [2:0]         in_func;
  logic [7:0]         in_u, in_v;
  logic [4:0]         in_ku, in_kv;
  logic signed [15:0] in_sr, in_si;
  logic [31:0]        in_cr, in_ci;
  assign in_func = s_axis_tdata[2:0];
  assign in_u    = s_axis_tdata[10:3];
  assign in_v    = s_axis_tdata[18:11];
  assign in_ku   = s_axis_tdata[23:19];
  assign in_kv   = s_axis_tdata[28:24];
  assign in_sr   = s_axis_tdata[44:29];
  assign in_si   = s_axis_tdata[60:45];
  assign in_cr   = s_axis_tdata[92:61];
  assign in_ci   = s_axis_tdata[124:93];

  logic [3:0] s_eff;
  logic [4:0] s2;
  assign s_eff = (32'(support_q) > MAX_SUPPORT) ? 4'(MAX_SUPPORT) : support_q;
  assign s2    = {s_eff, 1'b0};

  logic win_out, cell_out, kidx_bad;
  assign win_out = (in_u < {4'd0, s_eff}) || (in_v < {4'd0, s_eff}) ||
                   (CW'(in_u) + CW'(s_eff) >= CW'(GRID_SIDE)) ||
                   (CW'(in_v) + CW'(s_eff) >= CW'(GRID_SIDE));
  assign cell_out = (CW'(in_u) >= CW'(GRID_SIDE)) || (CW'(in_v) >= CW'(GRID_SIDE));
  assign kidx_bad = (KCW'(in_ku) >= KCW'(KSIDE)) || (KCW'(in_kv) >= KCW'(KSIDE));

  logic [AW-1:0] cell_addr, win_base;
  logic [KW-1:0] kw_addr;
  assign cell_addr = AW'(AW'(in_v) * AW'(GRID_SIDE)) + AW'(in_u);
  assign win_base  = AW'(AW'(in_v - {4'd0, s_eff}) * AW'(GRID_SIDE))
                   + AW'(in_u - {4'd0, s_eff});
  assign kw_addr   = KW'(KW'(in_kv) * KW'(KSIDE)) + KW'(in_ku);

  logic accept;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // memories
  logic [63:0] grid_mem [GRID_SIDE*GRID_SIDE];
  logic [31:0] kern_mem [KSIDE*KSIDE];
  logic          g_we, k_we;
  logic [AW-1:0] g_waddr, g_raddr;
  logic [63:0]   g_wdata, g_rdata_q;
  logic [KW-1:0] k_waddr, k_raddr;
  logic [31:0]   k_rdata_q;

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      grid_mem[g_waddr] <= g_wdata;
    end
    if (k_we) begin
      kern_mem[k_waddr] <= {in_si, in_sr};
    end
    g_rdata_q <= grid_mem[g_raddr];
    k_rdata_q <= kern_mem[k_raddr];
  end

  // window walk
  logic [AW-1:0] ga_q;
  logic [KW-1:0] ka_q;
  logic [4:0]    du_q, dv_q;
  logic signed [15:0] sr_q, si_q;
  logic row_end, last_cell;
  assign row_end   = (du_q == s2);
  assign last_cell = row_end && (dv_q == s2);

  assign g_raddr = (state_q == S_RUN) ? ga_q : cell_addr;
  assign k_raddr = ka_q;

  // pipeline
  logic          p1_v_q, p2_v_q;
  logic [AW-1:0] p1_addr_q, p2_addr_q;
  logic signed [48:0] p2_re_q, p2_im_q;
  logic signed [31:0] p2_gr_q, p2_gi_q;
  logic signed [63:0] acc_re_q, acc_im_q;
  logic sat_q;

  logic signed [31:0] gr, gi;
  logic signed [15:0] wr, wi;
  logic signed [48:0] m_re, m_im;
  assign gr = g_rdata_q[31:0];
  assign gi = g_rdata_q[63:32];
  assign wr = k_rdata_q[15:0];
  assign wi = k_rdata_q[31:16];

  always_comb begin
    if (mode_q == FUNC_GRID) begin
      m_re = 49'(sr_q * wr) - 49'(si_q * wi);
      m_im = 49'(sr_q * wi) + 49'(si_q * wr);
    end else begin
      m_re = 49'(gr * wr) + 49'(gi * wi);
      m_im = 49'(gr * wi) - 49'(gi * wr);
    end
  end

  logic [32:0] c_re, c_im;
  assign c_re = clamp32(64'(p2_gr_q) + 64'(p2_re_q));
  assign c_im = clamp32(64'(p2_gi_q) + 64'(p2_im_q));

  logic signed [63:0] rnd_re, rnd_im;
  logic [32:0] f_re, f_im;
  assign rnd_re = (acc_re_q + 64'sd16384) >>> 15;
  assign rnd_im = (acc_im_q + 64'sd16384) >>> 15;
  assign f_re   = clamp32(rnd_re);
  assign f_im   = clamp32(rnd_im);

  always_comb begin
    g_we    = 1'b0;
    g_waddr = p2_addr_q;
    g_wdata = {c_im[31:0], c_re[31:0]};
    k_we    = accept && (in_func == FUNC_WR_KERN) && !kidx_bad;
    k_waddr = kw_addr;
    if (accept && (in_func == FUNC_WR_CELL) && !cell_out) begin
      g_we    = 1'b1;
      g_waddr = cell_addr;
      g_wdata = {in_ci, in_cr};
    end else if (p2_v_q && (mode_q == FUNC_GRID)) begin
      g_we = 1'b1;
    end
  end

  logic [31:0] res_re_q, res_im_q;
  logic [1:0]  res_st_q;
  logic        m_valid_q;
  logic [65:0] m_data_q;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(m_data_q);

  always_ff @(posedge clk_i) begin
    p1_addr_q <= ga_q;
    p2_addr_q <= p1_addr_q;
    p2_re_q   <= m_re;
    p2_im_q   <= m_im;
    p2_gr_q   <= gr;
    p2_gi_q   <= gi;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      support_q <= SUPPORT_RST;
      mode_q    <= FUNC_WR_KERN;
      ga_q      <= '0;
      ka_q      <= '0;
      du_q      <= '0;
      dv_q      <= '0;
      sr_q      <= '0;
      si_q      <= '0;
      p1_v_q    <= 1'b0;
      p2_v_q    <= 1'b0;
      acc_re_q  <= '0;
      acc_im_q  <= '0;
      sat_q     <= 1'b0;
      res_re_q  <= '0;
      res_im_q  <= '0;
      res_st_q  <= ST_OK;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        support_q <= cfg_data_i;
      end
      if (m_valid_q && m_axis_tready && (state_q != S_DONE)) begin
        m_valid_q <= 1'b0;
      end
      p1_v_q <= (state_q == S_RUN);
      p2_v_q <= p1_v_q;
      if (p2_v_q) begin
        if (mode_q == FUNC_GRID) begin
          sat_q <= sat_q | c_re[32] | c_im[32];
        end else begin
          acc_re_q <= acc_re_q + 64'(p2_re_q);
          acc_im_q <= acc_im_q + 64'(p2_im_q);
        end
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            mode_q   <= in_func;
            sr_q     <= in_sr;
            si_q     <= in_si;
            ga_q     <= win_base;
            ka_q     <= '0;
            du_q     <= '0;
            dv_q     <= '0;
            acc_re_q <= '0;
            acc_im_q <= '0;
            sat_q    <= 1'b0;
            res_re_q <= '0;
            res_im_q <= '0;
            case (in_func)
              FUNC_WR_KERN: begin
                res_st_q <= kidx_bad ? ST_KIDX : ST_OK;
                state_q  <= S_DONE;
              end
              FUNC_WR_CELL: begin
                res_st_q <= cell_out ? ST_OUTSIDE : ST_OK;
                state_q  <= S_DONE;
              end
              FUNC_RD_CELL: begin
                res_st_q <= cell_out ? ST_OUTSIDE : ST_OK;
                state_q  <= cell_out ? S_DONE : S_RD;
              end
              FUNC_GRID, FUNC_DEGRID: begin
                res_st_q <= win_out ? ST_OUTSIDE : ST_OK;
                state_q  <= win_out ? S_DONE : S_RUN;
              end
              default: begin
                res_st_q <= ST_OK;
                state_q  <= S_DONE;
              end
            endcase
          end
        end
        S_RUN: begin
          if (row_end) begin
            du_q <= '0;
            dv_q <= dv_q + 5'd1;
            ga_q <= ga_q + AW'(GRID_SIDE) - AW'(s2);
            ka_q <= ka_q + KW'(KSIDE) - KW'(s2);
          end else begin
            du_q <= du_q + 5'd1;
            ga_q <= ga_q + AW'(1);
            ka_q <= ka_q + KW'(1);
          end
          if (last_cell) state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!p1_v_q && !p2_v_q) begin
            if (mode_q == FUNC_DEGRID) begin
              res_re_q <= f_re[31:0];
              res_im_q <= f_im[31:0];
              if (f_re[32] || f_im[32]) res_st_q <= ST_SAT;
            end else if (sat_q) begin
              res_st_q <= ST_SAT;
            end
            state_q <= S_DONE;
          end
        end
        S_RD: begin
          res_re_q <= gr;
          res_im_q <= gi;
          state_q  <= S_DONE;
        end
        S_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {res_st_q, res_im_q, res_re_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/cgd_checker.sv -----
// ----------------------------------------------------------------------------
// cgd_checker
// Port-level checks of the gridding/degridding engine.
// ----------------------------------------------------------------------------
module cgd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);
  import cgd_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command taken while busy");

  a_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[65:64] == ST_OUTSIDE) |-> m_axis_tdata[63:0] == '0)
    else $error("nonzero data with outside status");

  a_kidx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[65:64] == ST_KIDX) |-> m_axis_tdata[63:0] == '0)
    else $error("nonzero data with kernel index status");

endmodule

bind convolutional_gridding_degridding cgd_checker u_cgd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
